// ===== rtl/teq_pkg.sv =====
package teq_pkg;

  localparam int DEF_SLOTS = 8;

  // operation codes carried in the mode field
  localparam logic [2:0] MODE_CHECK     = 3'd0;
  localparam logic [2:0] MODE_ADD_AT    = 3'd1;
  localparam logic [2:0] MODE_ADD_DELAY = 3'd2;
  localparam logic [2:0] MODE_ADD_CB    = 3'd3;
  localparam logic [2:0] MODE_QUERY     = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] current_time;
    logic [31:0] time_value;
    logic [7:0]  pin_id;
    logic [7:0]  pin_value;
    logic [7:0]  callback_tag;
  } teq_in_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_pin;
    logic [7:0] fired_value;
    logic [7:0] fired_tag;
    logic       tag_found;
    logic       evicted;
  } teq_out_t;

  typedef struct packed {
    logic [31:0] due;
    logic [7:0]  pin;
    logic [7:0]  value;
    logic [7:0]  tag;
  } teq_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take the input word, clear the result
    logic pop;       // drop the head entry
    logic evict;     // flag the drop in the result
    logic rd_head;   // read the head entry
    logic fire;      // evaluate the head entry against the current time
    logic rd_ins;    // first read of the insertion walk
    logic ins_step;  // one step of the insertion walk
    logic qry_step;  // one step of the tag scan
    logic out_load;  // move the result into the output register
  } teq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;       // every slot live
    logic ins_place;  // the new entry lands at the walk position now
    logic qry_more;   // tag scan has entries left to read
  } teq_stat_t;

endpackage

// ===== rtl/teq_ctrl.sv =====
module teq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_mode,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  teq_pkg::teq_stat_t st,
  output teq_pkg::teq_cmd_t  cmd
);
  import teq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK_EVAL,
    S_INS_RD,
    S_INS_CMP,
    S_QRY,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_mode)
            MODE_CHECK: state_nxt = S_CHK_RD;
            MODE_ADD_AT, MODE_ADD_DELAY, MODE_ADD_CB: begin
              if (st.full) begin
                cmd.pop   = 1'b1;
                cmd.evict = 1'b1;
              end
              state_nxt = S_INS_RD;
            end
            MODE_QUERY: state_nxt = S_QRY;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_CHK_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_CHK_EVAL;
      end
      S_CHK_EVAL: begin
        cmd.fire  = 1'b1;
        state_nxt = S_FIN;
      end
      S_INS_RD: begin
        cmd.rd_ins = 1'b1;
        state_nxt  = S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd.ins_step = 1'b1;
        if (st.ins_place) state_nxt = S_FIN;
      end
      S_QRY: begin
        cmd.qry_step = 1'b1;
        if (!st.qry_more) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/teq_dpath.sv =====
module teq_dpath #(
  parameter int SLOTS = teq_pkg::DEF_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  teq_pkg::teq_in_t  in_word,
  input  teq_pkg::teq_cmd_t cmd,
  output teq_pkg::teq_stat_t st,
  output teq_pkg::teq_out_t out_word
);
  import teq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // ring of entries, head is the earliest; logical order == due order
  teq_entry_t mem [SLOTS];
  teq_entry_t rdata_r;

  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          pend_r, pend_nxt;
  teq_entry_t    key_r, key_nxt;
  logic [31:0]   now_r;
  teq_out_t      res_r, res_nxt;
  teq_out_t      out_r;

  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  teq_entry_t    wdata;
  logic          we;
  logic          pop;
  logic          fire_ok;
  logic          is_add;
  logic [CW-1:0] j_m1, j_m2;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(SLOTS)) s = s - (CW+1)'(SLOTS);
    return s[IW-1:0];
  endfunction

  assign j_m1 = (j_r == '0) ? '0 : j_r - CW'(1);
  assign j_m2 = (j_r < CW'(2)) ? '0 : j_r - CW'(2);

  assign st.full      = (count_r == CW'(SLOTS));
  assign st.ins_place = (j_r == '0) || !(rdata_r.due > key_r.due);
  assign st.qry_more  = (j_r < count_r);

  assign is_add  = (in_word.mode == MODE_ADD_AT) || (in_word.mode == MODE_ADD_DELAY) ||
                   (in_word.mode == MODE_ADD_CB);
  assign fire_ok = cmd.fire && (count_r != '0) && (now_r > rdata_r.due);
  assign pop     = cmd.pop | fire_ok;

  always_comb begin
    raddr = head_r;
    if (cmd.rd_head)  raddr = head_r;
    if (cmd.rd_ins)   raddr = phys(head_r, j_m1);
    if (cmd.ins_step) raddr = phys(head_r, j_m2);
    if (cmd.qry_step) raddr = phys(head_r, j_r);
  end

  assign we    = cmd.ins_step;
  assign waddr = phys(head_r, j_r);
  assign wdata = st.ins_place ? key_r : rdata_r;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    j_nxt     = j_r;
    pend_nxt  = pend_r;
    key_nxt   = key_r;
    res_nxt   = res_r;

    if (pop) begin
      head_nxt  = phys(head_r, CW'(1));
      count_nxt = count_r - CW'(1);
    end

    if (cmd.load) begin
      key_nxt.due   = (in_word.mode == MODE_ADD_AT) ? in_word.time_value
                                                    : in_word.current_time + in_word.time_value;
      key_nxt.pin   = (in_word.mode == MODE_ADD_CB) ? 8'd0 : in_word.pin_id;
      key_nxt.value = (in_word.mode == MODE_ADD_CB) ? 8'd0 : in_word.pin_value;
      key_nxt.tag   = ((in_word.mode == MODE_ADD_CB) || (in_word.mode == MODE_QUERY))
                      ? in_word.callback_tag : 8'd0;
      res_nxt         = '0;
      res_nxt.evicted = cmd.evict;
      pend_nxt        = 1'b0;
      if (cmd.pop)     j_nxt = CW'(SLOTS - 1);
      else if (is_add) j_nxt = count_r;
      else             j_nxt = '0;
    end

    if (fire_ok) begin
      res_nxt.fired       = 1'b1;
      res_nxt.fired_pin   = rdata_r.pin;
      res_nxt.fired_value = rdata_r.value;
      res_nxt.fired_tag   = rdata_r.tag;
    end

    if (cmd.ins_step) begin
      if (st.ins_place) count_nxt = count_r + CW'(1);
      else              j_nxt     = j_m1;
    end

    if (cmd.qry_step) begin
      if (pend_r && (key_r.tag != 8'd0) && (rdata_r.tag == key_r.tag)) res_nxt.tag_found = 1'b1;
      if (st.qry_more) begin
        pend_nxt = 1'b1;
        j_nxt    = j_r + CW'(1);
      end else begin
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
    if (cmd.load)     now_r <= in_word.current_time;
    if (cmd.out_load) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign out_word = out_r;

endmodule

// ===== rtl/timed_event_queue_unit.sv =====
// Timed event queue: holds up to SLOTS pending events (pin writes or callback
// tags) in due-time order and answers one result word for every input word.
// Mode selects check (fire and remove the earliest event once current_time is
// strictly past its due time, at most one per check), add at an absolute time,
// add after a delay (current_time + delay, wrapping at 32 bits), add a callback
// after a delay, or query whether a nonzero tag is pending. An event that ties
// pending due times goes after them. Adding to a full queue drops the earliest
// event unfired and sets evicted. Entries sit in a ring in one memory with a
// registered read port, head at the earliest event; firing or eviction just
// advances the head. A check reads the head entry and then evaluates it; an add
// walks back from the tail, moving each pending event due strictly later than
// the new one a slot on, one entry read and one entry moved per cycle; a query
// reads each pending entry in turn. The result sits in an output register, so
// the next input word is taken while a result word still waits on out_ready.
// No clearing pass after reset: only live ring entries ever affect a result.
module timed_event_queue_unit #(
  parameter int SLOTS = teq_pkg::DEF_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  teq_pkg::teq_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output teq_pkg::teq_out_t out_word
);
  import teq_pkg::*;

  teq_cmd_t  cmd;
  teq_stat_t st;

  // sequencing: accept, memory walk, then hand-off to the output register
  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_word.mode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  // ring memory, head/count, walk index and result word
  teq_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .st       (st),
    .out_word (out_word)
  );

endmodule

// ===== sim/timed_event_queue_checker.sv =====
`timescale 1ns / 1ps
module timed_event_queue_checker #(
  parameter int SLOTS = teq_pkg::DEF_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  teq_pkg::teq_in_t  in_word,
  input  logic              out_valid,
  input  logic              out_ready,
  input  teq_pkg::teq_out_t out_word,
  output int                errors,
  output int                waiting,
  output int                words_in,
  output int                fires,
  output int                evictions,
  output int                tag_hits
);
  import teq_pkg::*;

  localparam int SHOW_MAX = 10;

  teq_entry_t shadow_events[$];  // pending events, earliest first
  teq_out_t   due_results[$];    // result words not yet seen on the output

  // Applies one input word to the shadow queue, returns the result word it owes.
  function automatic teq_out_t schedule_and_fire(teq_in_t w);
    teq_out_t   r;
    teq_entry_t ev;
    int         pos;
    r = '0;
    ev = '0;
    case (w.mode)
      MODE_CHECK: begin
        if (shadow_events.size() > 0 && w.current_time > shadow_events[0].due) begin
          r.fired       = 1'b1;
          r.fired_pin   = shadow_events[0].pin;
          r.fired_value = shadow_events[0].value;
          r.fired_tag   = shadow_events[0].tag;
          void'(shadow_events.pop_front());
        end
      end
      MODE_ADD_AT, MODE_ADD_DELAY, MODE_ADD_CB: begin
        // 32-bit sum wraps on its own
        ev.due = (w.mode == MODE_ADD_AT) ? w.time_value : w.current_time + w.time_value;
        if (w.mode == MODE_ADD_CB) begin
          ev.tag = w.callback_tag;
        end else begin
          ev.pin   = w.pin_id;
          ev.value = w.pin_value;
        end
        if (shadow_events.size() >= SLOTS) begin
          void'(shadow_events.pop_front());
          r.evicted = 1'b1;
        end
        // ties go behind the events already pending
        pos = 0;
        while (pos < shadow_events.size() && shadow_events[pos].due <= ev.due) pos++;
        shadow_events.insert(pos, ev);
      end
      MODE_QUERY: begin
        if (w.callback_tag != 8'd0) begin
          foreach (shadow_events[i]) begin
            if (shadow_events[i].tag == w.callback_tag) r.tag_found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    teq_out_t want;
    if (rst_n) begin
      // outgoing first; the matching word was always taken at an earlier edge
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          if (errors < SHOW_MAX)
            $display("%0t: result word with none outstanding: fired %0d pin %02h value %02h tag %02h found %0d evicted %0d",
                     $realtime, out_word.fired, out_word.fired_pin, out_word.fired_value,
                     out_word.fired_tag, out_word.tag_found, out_word.evicted);
          errors <= errors + 1;
        end else begin
          want = due_results.pop_front();
          if (out_word.fired !== want.fired || out_word.fired_pin !== want.fired_pin ||
              out_word.fired_value !== want.fired_value ||
              out_word.fired_tag !== want.fired_tag ||
              out_word.tag_found !== want.tag_found || out_word.evicted !== want.evicted) begin
            if (errors < SHOW_MAX) begin
              $display("%0t: mismatch, expected fired %0d pin %02h value %02h tag %02h found %0d evicted %0d",
                       $realtime, want.fired, want.fired_pin, want.fired_value,
                       want.fired_tag, want.tag_found, want.evicted);
              $display("%0t:           actual fired %0d pin %02h value %02h tag %02h found %0d evicted %0d",
                       $realtime, out_word.fired, out_word.fired_pin, out_word.fired_value,
                       out_word.fired_tag, out_word.tag_found, out_word.evicted);
            end
            errors <= errors + 1;
          end
          fires     <= fires + want.fired;
          evictions <= evictions + want.evicted;
          tag_hits  <= tag_hits + want.tag_found;
        end
      end
      if (in_valid && in_ready) begin
        due_results = {due_results, schedule_and_fire(in_word)};
        words_in <= words_in + 1;
      end
    end
    waiting <= due_results.size();
  end

endmodule

// ===== sim/timed_event_queue_unit_test.sv =====
`timescale 1ns / 1ps
module timed_event_queue_unit_test;
  import teq_pkg::*;

  localparam int SLOTS        = DEF_SLOTS;
  localparam int HALF_PERIOD  = 6;        // 12 ns clock
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_PCT     = 29;       // chance per cycle that a side sits out
  localparam int HOLD_CYCLES  = 80;       // one long output stall
  localparam int LIMIT_CYCLES = 200_000;  // far past the slowest legal run
  localparam int TAIL_CYCLES  = SLOTS + 8;

  // modes the block must ignore
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  teq_in_t   in_word;
  logic      out_valid;
  logic      out_ready;
  teq_out_t  out_word;

  // knobs for the two driver processes (sim_now is the sender's alone)
  logic        idle_on;
  int          hold_asks;   // bumped by the sender side to request a long output stall
  logic [31:0] sim_now;     // running time base for the well-formed random words

  // checker outputs
  int errors;
  int waiting;
  int words_in;
  int fires;
  int evictions;
  int tag_hits;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  timed_event_queue_unit #(.SLOTS(SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  timed_event_queue_checker #(.SLOTS(SLOTS)) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .errors    (errors),
    .waiting   (waiting),
    .words_in  (words_in),
    .fires     (fires),
    .evictions (evictions),
    .tag_hits  (tag_hits)
  );

  function automatic teq_in_t word_of(logic [2:0] mode, logic [31:0] now, logic [31:0] tval,
                                      logic [7:0] pin, logic [7:0] val, logic [7:0] tag);
    teq_in_t w;
    w.mode         = mode;
    w.current_time = now;
    w.time_value   = tval;
    w.pin_id       = pin;
    w.pin_value    = val;
    w.callback_tag = tag;
    return w;
  endfunction

  // Offers one word and returns at the edge that takes it. Called at a rising
  // edge; valid is only dropped when a gap is actually inserted, so valid sees
  // one assignment per edge and stays high across back-to-back words.
  task automatic send_word(teq_in_t w);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    // in_ready read at the edge is its value before the edge: the one that counts
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender pause: nothing offered until every owed result word has come out.
  // Polled on the falling edge so the checker's count is settled.
  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    @(posedge clk);
  endtask

  // Mostly coherent traffic around a moving time base: checks that advance the
  // clock, adds due a little ahead (or just behind), callbacks with a small tag
  // pool so queries hit, plus a slice of fully random words for the corners.
  task automatic run_random(int count);
    int          pick;
    logic [7:0]  tag;
    teq_in_t     w;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      tag  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
      if (pick < 15) begin
        // noise: every field full range, unused modes included
        w = word_of(3'($urandom_range(0, 7)), $urandom, $urandom,
                    8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 48) begin
        if ($urandom_range(0, 39) == 0) sim_now = sim_now + $urandom_range(100, 5000);
        else sim_now = sim_now + $urandom_range(0, 24);
        w = word_of(MODE_CHECK, sim_now, $urandom, 8'($urandom), 8'($urandom), tag);
      end else if (pick < 64) begin
        w = word_of(MODE_ADD_DELAY, sim_now, $urandom_range(0, 40),
                    8'($urandom), 8'($urandom), tag);
      end else if (pick < 78) begin
        w = word_of(MODE_ADD_CB, sim_now, $urandom_range(0, 40),
                    8'($urandom), 8'($urandom), tag);
      end else if (pick < 88) begin
        // absolute time, sometimes already in the past
        w = word_of(MODE_ADD_AT, sim_now, sim_now + $urandom_range(0, 48) - 32'd8,
                    8'($urandom), 8'($urandom), tag);
      end else begin
        w = word_of(MODE_QUERY, sim_now, $urandom, 8'($urandom), 8'($urandom), tag);
      end
      send_word(w);
    end
  endtask

  // Output side: random back-pressure, plus one long stall on request. The
  // stall is counted here so the sender keeps offering words the whole time.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("timeout: %0d words taken, %0d result words still owed", words_in, waiting);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    idle_on   <= 1'b1;
    hold_asks <= 0;
    sim_now    = 32'd0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // empty queue: check and a query of tag zero give all zeros
    send_word(word_of(MODE_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(word_of(MODE_QUERY, 32'd0, 32'd0, 8'd0, 8'd0, 8'd0));
    // two pin events at time zero, the second ties the first; tag must be dropped
    send_word(word_of(MODE_ADD_AT, 32'd0, 32'd0, 8'hFF, 8'hFF, 8'hFF));
    send_word(word_of(MODE_ADD_AT, 32'd0, 32'd0, 8'h01, 8'h02, 8'h00));
    // delayed add that wraps past 2^32, with zero pin and value
    send_word(word_of(MODE_ADD_DELAY, 32'hFFFF_FFF0, 32'h0000_0020, 8'h00, 8'h00, 8'h33));
    // callback with zero delay; pin and value must not be stored
    send_word(word_of(MODE_ADD_CB, 32'd5, 32'd0, 8'h55, 8'h66, 8'hAA));
    send_word(word_of(MODE_QUERY, 32'd0, 32'd0, 8'd0, 8'd0, 8'hAA));
    send_word(word_of(MODE_QUERY, 32'd0, 32'd0, 8'd0, 8'd0, 8'hFF));
    // not due at equal time, due one later; ties fire in arrival order
    send_word(word_of(MODE_CHECK, 32'd0, 32'd0, 8'd0, 8'd0, 8'd0));
    send_word(word_of(MODE_CHECK, 32'd1, 32'd0, 8'd0, 8'd0, 8'd0));
    send_word(word_of(MODE_CHECK, 32'd1, 32'd0, 8'd0, 8'd0, 8'd0));
    // latest possible due time, then fill past capacity with a run of ties
    send_word(word_of(MODE_ADD_AT, 32'd0, 32'hFFFF_FFFF, 8'h80, 8'h7F, 8'd0));
    for (int k = 0; k < 7; k++) begin
      send_word(word_of(MODE_ADD_AT, 32'd0, 32'd100, 8'(k + 16), 8'(k), 8'd0));
    end
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
      send_word(word_of(3'(m), $urandom, $urandom, 8'($urandom), 8'($urandom), 8'hAA));
    end
    send_word(word_of(MODE_CHECK, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'd0, 8'd0));
    // callback with tag zero still stores and later fires
    send_word(word_of(MODE_ADD_CB, 32'd50, 32'd3, 8'd0, 8'd0, 8'd0));
    send_word(word_of(MODE_CHECK, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'd0, 8'd0));
    drain_wait();

    // --- random ---
    // half the seeds start just short of the 32-bit wrap
    sim_now = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FF80;
    run_random(200);
    // back-to-back stretch with one long output stall: the block fills and
    // stops taking input words while the sender keeps valid up
    idle_on   <= 1'b0;
    hold_asks <= hold_asks + 1;
    run_random(150);
    drain_wait();
    idle_on <= 1'b1;
    run_random(250);

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words in, %0d checks fired, %0d evictions, %0d tag hits", words_in, fires,
             evictions, tag_hits);
    $display("covered idle and back-to-back phases, a long output stall and full drains");
    if (errors == 0 && waiting == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d result words never seen", errors, waiting);
      $display("FAIL");
    end
    $finish;
  end

endmodule
